// File: sv/sha256_stream_hash_defines.svh
// Assertion macros for the SHA-256 stream hasher.
`ifndef SHA256_STREAM_HASH_DEFINES_SVH
`define SHA256_STREAM_HASH_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define SHS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define SHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SHS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SHS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: sv/shs_pkg.sv
package shs_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FINAL,
        S_EMIT
    } t_state;

    localparam logic       ACT_ABSORB = 1'b0;
    localparam logic       ACT_FINISH = 1'b1;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

// File: sv/sha256_stream_hash.sv
// Channel   Direction  Handshake                  Payload
// in        sink       i_in_valid / o_in_ready    i_action, i_msg_byte
// out       source     o_out_valid / i_out_ready  o_digest_part0 .. o_digest_part3
//
// An absorb transaction loads one byte; one that fills the 64-byte block also runs the
// rounds through the single round unit and one hash update.
// A finish feeds one pad or length byte per cycle outside compressions, 9 to 72 bytes,
// compresses each block that it fills and then loads the digest.
// Synchronous active-low reset restores the initial hash, empties the block and drops
// any pending digest. A stalled digest holds; absorbs go on, a finish waits for it.
module sha256_stream_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [7:0]  i_msg_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_digest_part0,
    output logic [63:0] o_digest_part1,
    output logic [63:0] o_digest_part2,
    output logic [63:0] o_digest_part3
);
    import shs_pkg::*;
`include "sha256_stream_hash_defines.svh"

    // Sequencer and control state
    t_state      r_state, n_state;
    logic [5:0]  r_fill;       // bytes held in the block shift line
    logic [63:0] r_len;        // message bytes absorbed so far
    logic [5:0]  r_round;
    logic        r_fin;        // finish in progress
    logic        r_lenph;      // length bytes being fed
    logic        r_last;       // current compression closes the message
    logic        r_out_valid;

    // Datapath
    logic [31:0]  r_h [8];     // chaining hash
    logic [31:0]  r_v [8];     // working variables a..h
    logic [511:0] r_blk;       // block bytes, then the 16-word schedule window
    logic [63:0]  r_bits;      // bit length, shifted out a byte at a time
    logic [63:0]  r_dig [4];

    logic         in_fire;
    logic         out_free;
    logic         push;
    logic [7:0]   push_byte;
    logic [5:0]   fill_next;
    logic         wrap;
    logic         len_ph;

    logic [31:0]  w0, w1, w9, w14, w_new;
    logic [31:0]  t1, t2;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_digest_part0 = r_dig[0];
    assign o_digest_part1 = r_dig[1];
    assign o_digest_part2 = r_dig[2];
    assign o_digest_part3 = r_dig[3];

    // Length bytes start once zero fill reaches byte 56 of the block
    assign len_ph    = r_lenph || (r_fill == LEN_POS);
    assign fill_next = r_fill + 6'd1;
    assign wrap      = push && (fill_next == 6'd0);

    // Byte source for the block shift line
    always_comb begin
        push      = 1'b0;
        push_byte = 8'h00;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    push      = 1'b1;
                    push_byte = (i_action == ACT_FINISH) ? PAD_BYTE : i_msg_byte;
                end
            end
            S_PAD: begin
                push      = 1'b1;
                push_byte = len_ph ? r_bits[63:56] : 8'h00;
            end
            default: begin
                push      = 1'b0;
                push_byte = 8'h00;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (wrap) begin
                        n_state = S_ROUND;
                    end else if (i_action == ACT_FINISH) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (wrap) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_round == ROUND_LAST) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (r_last) begin
                    n_state = S_EMIT;
                end else if (r_fin) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Round unit: one compression round and one schedule word per cycle
    assign w0    = r_blk[511:480];
    assign w1    = r_blk[479:448];
    assign w9    = r_blk[223:192];
    assign w14   = r_blk[63:32];
    assign w_new = w0 + small_sigma0(w1) + w9 + small_sigma1(w14);

    assign t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + ROUND_K[r_round] + w0;
    assign t2 = big_sigma0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= 6'd0;
            r_len       <= 64'd0;
            r_round     <= 6'd0;
            r_fin       <= 1'b0;
            r_lenph     <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= HASH_IV[i];
            end
        end else begin
            r_state <= n_state;
            if (push) begin
                r_fill <= fill_next;
            end
            if (in_fire && (i_action == ACT_ABSORB)) begin
                r_len <= r_len + 64'd1;
            end
            if (in_fire && (i_action == ACT_FINISH)) begin
                r_fin <= 1'b1;
            end
            if ((r_state == S_PAD) && len_ph) begin
                r_lenph <= 1'b1;
                if (wrap) begin
                    r_last <= 1'b1;
                end
            end
            if (r_state == S_ROUND) begin
                r_round <= r_round + 6'd1;
            end
            if (r_state == S_FINAL) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            // Hand off the digest and start the next message from scratch
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
                r_len       <= 64'd0;
                r_fin       <= 1'b0;
                r_lenph     <= 1'b0;
                r_last      <= 1'b0;
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= HASH_IV[i];
                end
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire && (i_action == ACT_FINISH)) begin
            r_bits <= {r_len[60:0], 3'b000};
        end else if ((r_state == S_PAD) && len_ph) begin
            r_bits <= {r_bits[55:0], 8'h00};
        end
        if (push) begin
            r_blk <= {r_blk[503:0], push_byte};
        end else if (r_state == S_ROUND) begin
            r_blk <= {r_blk[479:0], w_new};
        end
        if (wrap) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (r_state == S_ROUND) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
        if ((r_state == S_EMIT) && out_free) begin
            for (int i = 0; i < 4; i++) begin
                r_dig[i] <= {r_h[2 * i], r_h[2 * i + 1]};
            end
        end
    end

    // Round counter runs only inside a compression
    `SHS_ASSERT(a_round_idle, i_clk, i_rst_n, (r_state != S_ROUND) |-> (r_round == 6'd0), "round counter active outside compression")
    // Compression starts only on a full block
    `SHS_ASSERT(a_round_fill, i_clk, i_rst_n, (r_state == S_ROUND) |-> (r_fill == 6'd0), "compression with partial block")
    // No finish bookkeeping survives back to idle
    `SHS_ASSERT(a_idle_clean, i_clk, i_rst_n, (r_state == S_IDLE) |-> (!r_fin && !r_lenph && !r_last), "finish flags left set in idle")
    // Digest hand-off leaves a fresh message state
    `SHS_ASSERT(a_emit_reinit, i_clk, i_rst_n, ((r_state == S_EMIT) && out_free) |=> (o_out_valid && (r_len == 64'd0) && (r_fill == 6'd0)), "message state not reinitialized after digest")
endmodule
